[src/ffha_pkg.sv]
package ffha_pkg;

   localparam int FREE_SEGMENTS   = 16;
   localparam int LIVE_BLOCKS     = 64;
   localparam int ALIGN_BYTES     = 8;
   localparam int HEADER_BYTES    = 8;
   localparam int MIN_BLOCK_BYTES = 32;
   localparam int HEAP_LIMIT      = 16777216;

   localparam int SEG_IDX_W  = $clog2(FREE_SEGMENTS);
   localparam int SEG_CNT_W  = $clog2(FREE_SEGMENTS + 1);
   localparam int LIVE_IDX_W = $clog2(LIVE_BLOCKS);
   localparam int LIVE_CNT_W = $clog2(LIVE_BLOCKS + 1);
   localparam int ALIGN_W    = $clog2(ALIGN_BYTES);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
   localparam logic [2:0] ST_NO_MEMORY  = 3'd2;
   localparam logic [2:0] ST_NULL_FREE  = 3'd3;
   localparam logic [2:0] ST_UNTRACKED  = 3'd4;
   localparam logic [2:0] ST_OUT_RANGE  = 3'd5;
   localparam logic [2:0] ST_TABLE_FULL = 3'd6;

   localparam logic CSR_HEAP_START = 1'b0;
   localparam logic CSR_HEAP_BYTES = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture request word
      logic seg_clear;   // reset segment scan index
      logic seg_step;    // advance segment scan
      logic live_clear;  // reset live scan index
      logic live_step;   // advance live scan
      logic alloc_commit;
      logic free_commit;
      logic shift_step;  // one entry of a table move
      logic set_error;
      logic [2:0] error_code;
      logic out_load;
   } ffha_cmd_type;

   typedef struct packed {
      logic op_free;
      logic zero_size;
      logic null_free;
      logic out_range;
      logic seg_done;    // scan past the count
      logic seg_hit;     // current entry matches
      logic live_done;
      logic live_hit;
      logic no_merge_full;
      logic shift_done;
   } ffha_sts_type;

endpackage

[src/first_fit_heap_allocator.sv]
// first-fit heap allocator: each word on req_ is an allocate or a free and gives exactly one
// rsp_ word. an allocate scans the address-sorted free table (16 entries) for the first
// fitting segment, then the live table (64 entries, read through its registered read port)
// for an empty slot; a free checks range, scans the live table for the block, then the free
// table for its place and merges with neighbors. a whole-segment take, a two-sided merge or
// an insert is followed by a table move that shifts the later segments by one place. an
// item can also wait for rsp_tready while an earlier word still sits in the result
// register. config writes rebuild the tables; write them only while idle. the result
// register lets a new request start while a word waits.
module first_fit_heap_allocator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // request_size[24:0], free_address[56:25], zero fill
   input  logic         req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // result_address[31:0], status[34:32], used[59:35],
                                     // free[84:60], total[109:85], zero fill
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_data
);
   ffha_pkg::ffha_cmd_type cmd;
   ffha_pkg::ffha_sts_type sts;
   logic idle, rsp_load;
   logic rsp_valid_ff;
   logic [31:0] o_addr;
   logic [2:0]  o_status;
   logic [24:0] o_used, o_free, o_total;

   assign req_tready = idle;
   assign csr_ready  = 1'b1;

   ffha_control u_control (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready),
      .rsp_busy(rsp_valid_ff),
      .rsp_fire(rsp_tvalid && rsp_tready),
      .idle(idle), .rsp_load(rsp_load), .sts(sts), .cmd(cmd)
   );

   ffha_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_we(csr_valid), .csr_index(csr_index[0]), .csr_value(csr_data),
      .req_op(req_tuser), .req_size(req_tdata[24:0]), .req_addr(req_tdata[56:25]),
      .out_address(o_addr), .out_status(o_status), .out_used(o_used),
      .out_free(o_free), .out_total(o_total)
   );

   // output word valid flag
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'd0, o_total, o_free, o_used, o_status, o_addr};
endmodule

[src/ffha_datapath.sv]
module ffha_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ffha_pkg::ffha_cmd_type cmd,
   output ffha_pkg::ffha_sts_type sts,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [31:0]           csr_value,
   input  logic                  req_op,
   input  logic [24:0]           req_size,
   input  logic [31:0]           req_addr,
   output logic [31:0]           out_address,
   output logic [2:0]            out_status,
   output logic [24:0]           out_used,
   output logic [24:0]           out_free,
   output logic [24:0]           out_total
);
   localparam int SN = ffha_pkg::FREE_SEGMENTS;
   localparam int SW = ffha_pkg::SEG_IDX_W;
   localparam int SC = ffha_pkg::SEG_CNT_W;
   localparam int LW = ffha_pkg::LIVE_IDX_W;
   localparam int LC = ffha_pkg::LIVE_CNT_W;
   localparam int AW = ffha_pkg::ALIGN_W;

   logic [31:0] heap_start_ff;
   logic [24:0] heap_bytes_ff;
   logic [31:0] base_ff;
   logic [24:0] total_ff;
   logic [24:0] used_ff;

   logic [31:0] seg_start_ff [SN];
   logic [24:0] seg_size_ff  [SN];
   logic [SC-1:0] seg_cnt_ff;

   logic [31:0] live_start_mem [ffha_pkg::LIVE_BLOCKS];
   logic [24:0] live_size_mem  [ffha_pkg::LIVE_BLOCKS];
   logic [ffha_pkg::LIVE_BLOCKS-1:0] live_valid_ff;

   logic        op_ff;
   logic [25:0] need_ff;
   logic [31:0] blk_ff;
   logic [31:0] boff_ff;
   logic [SC-1:0] si_ff;
   logic [LC-1:0] li_ff;
   logic [31:0] rd_start_ff;
   logic [24:0] rd_size_ff;
   logic        rd_valid_ff;
   logic        rd_ok_ff;
   logic [LW-1:0] slot_ff;
   logic [SC-1:0] seg_ff;
   logic        shift_up_ff;
   logic [SC-1:0] sh_ff;
   logic [31:0] res_addr_ff;
   logic [2:0]  res_status_ff;

   // config derived values
   logic [32:0] start_rnd;
   logic [24:0] bytes_sat;
   logic [31:0] base_in;
   logic [24:0] total_in;
   logic [31:0] hs_next;
   logic [24:0] hb_next;
   always_comb begin
      hs_next = (csr_we && csr_index == ffha_pkg::CSR_HEAP_START) ? csr_value : heap_start_ff;
      hb_next = (csr_we && csr_index == ffha_pkg::CSR_HEAP_BYTES) ? csr_value[24:0]
                                                                   : heap_bytes_ff;
      start_rnd = {1'b0, hs_next} + 33'(ffha_pkg::ALIGN_BYTES - 1);
      base_in   = {start_rnd[31:AW], AW'(0)};
      bytes_sat = (hb_next > 25'(ffha_pkg::HEAP_LIMIT)) ? 25'(ffha_pkg::HEAP_LIMIT) : hb_next;
      total_in  = {bytes_sat[24:AW], AW'(0)};
   end

   // request derived values
   logic [26:0] need_raw;
   logic [31:0] blk_c;
   always_comb begin
      need_raw = {2'b0, req_size} + 27'(ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES - 1);
      blk_c    = req_addr - 32'(ffha_pkg::HEADER_BYTES);
   end

   // segment reads at scan index and its predecessor
   logic [SW-1:0] si_idx, sp_idx;
   logic [31:0] cur_start, prev_start;
   logic [24:0] cur_size, prev_size;
   logic [31:0] cur_off, prev_off;
   logic seg_in;
   logic [32:0] prev_seg_end;
   logic [32:0] blk_end;
   logic mprev, mnext;
   always_comb begin
      si_idx       = si_ff[SW-1:0];
      sp_idx       = si_idx - SW'(1);
      cur_start    = seg_start_ff[si_idx];
      cur_size     = seg_size_ff[si_idx];
      prev_start   = seg_start_ff[sp_idx];
      prev_size    = seg_size_ff[sp_idx];
      cur_off      = cur_start - base_ff;
      prev_off     = prev_start - base_ff;
      seg_in       = si_ff < seg_cnt_ff;
      prev_seg_end = {1'b0, prev_off} + 33'(prev_size);
      blk_end      = {1'b0, boff_ff} + 33'(rd_size_ff);
      mprev        = (si_ff != '0) && prev_seg_end == {1'b0, boff_ff};
      mnext        = seg_in && blk_end == {1'b0, cur_off};
   end

   always_comb begin
      sts.op_free       = op_ff;
      sts.zero_size     = need_ff == '0;
      sts.null_free     = blk_ff == (32'd0 - 32'(ffha_pkg::HEADER_BYTES));
      sts.out_range     = boff_ff >= 32'(total_ff);
      sts.seg_done      = !seg_in;
      sts.seg_hit       = op_ff ? (cur_off > boff_ff) : ({1'b0, cur_size} >= need_ff);
      sts.live_done     = li_ff == LC'(ffha_pkg::LIVE_BLOCKS);
      sts.live_hit      = rd_ok_ff && (op_ff ? (rd_valid_ff && rd_start_ff == blk_ff)
                                             : !rd_valid_ff);
      sts.no_merge_full = !mprev && !mnext && seg_cnt_ff >= SC'(SN);
      sts.shift_done    = shift_up_ff ? (sh_ff <= seg_ff) : (sh_ff + SC'(1) >= seg_cnt_ff);
   end

   logic [LW-1:0] li_idx;
   assign li_idx = li_ff[LW-1:0];

   // live table: one read port on the scan index, held until the next step
   always_ff @(posedge clock) begin
      if (cmd.live_step) begin
         rd_start_ff <= live_start_mem[li_idx];
         rd_size_ff  <= live_size_mem[li_idx];
         rd_valid_ff <= live_valid_ff[li_idx];
      end
      if (cmd.alloc_commit) begin
         live_start_mem[slot_ff] <= cur_start;
         live_size_mem[slot_ff]  <= ({1'b0, cur_size} - need_ff >= 26'(ffha_pkg::MIN_BLOCK_BYTES))
                                    ? need_ff[24:0] : cur_size;
      end
   end

   logic [24:0] rest;
   assign rest = cur_size - need_ff[24:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_start_ff <= '0;
         heap_bytes_ff <= 25'(ffha_pkg::HEAP_LIMIT);
         base_ff       <= '0;
         total_ff      <= 25'(ffha_pkg::HEAP_LIMIT);
         used_ff       <= '0;
         seg_cnt_ff    <= SC'(1);
         live_valid_ff <= '0;
         seg_start_ff[0] <= '0;
         seg_size_ff[0]  <= 25'(ffha_pkg::HEAP_LIMIT);
         si_ff <= '0;
         li_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            heap_start_ff <= hs_next;
            heap_bytes_ff <= hb_next;
            base_ff  <= base_in;
            total_ff <= total_in;
            used_ff  <= '0;
            live_valid_ff <= '0;
            seg_cnt_ff <= (total_in != '0) ? SC'(1) : '0;
            seg_start_ff[0] <= base_in;
            seg_size_ff[0]  <= total_in;
         end
         if (cmd.load) begin
            op_ff   <= req_op;
            need_ff <= req_op ? 26'd1 : (req_size == '0 ? '0 : {need_raw[25:AW], AW'(0)});
            blk_ff  <= blk_c;
            boff_ff <= blk_c - base_ff;
         end
         if (cmd.seg_clear) si_ff <= '0;
         else if (cmd.seg_step) si_ff <= si_ff + SC'(1);
         if (cmd.live_clear) begin
            li_ff <= '0;
         end else if (cmd.live_step) begin
            li_ff <= li_ff + LC'(1);
         end
         rd_ok_ff <= cmd.live_step && !cmd.live_clear;
         if (cmd.alloc_commit) begin
            live_valid_ff[slot_ff] <= 1'b1;
            seg_ff <= si_ff;
            shift_up_ff <= 1'b0;
            res_addr_ff <= cur_start + 32'(ffha_pkg::HEADER_BYTES);
            res_status_ff <= ffha_pkg::ST_OK;
            if ({1'b0, cur_size} - need_ff >= 26'(ffha_pkg::MIN_BLOCK_BYTES)) begin
               seg_start_ff[si_idx] <= cur_start + 32'(need_ff);
               seg_size_ff[si_idx]  <= rest;
               used_ff <= used_ff + need_ff[24:0];
               sh_ff   <= seg_cnt_ff; // nothing to move
            end else begin
               used_ff <= used_ff + cur_size;
               seg_cnt_ff <= seg_cnt_ff - SC'(1);
               sh_ff <= si_ff;
            end
         end
         if (cmd.free_commit) begin
            live_valid_ff[slot_ff] <= 1'b0;
            used_ff <= (used_ff >= rd_size_ff) ? used_ff - rd_size_ff : '0;
            res_addr_ff <= '0;
            res_status_ff <= ffha_pkg::ST_OK;
            seg_ff <= si_ff;
            sh_ff  <= (mprev && mnext) ? si_ff : seg_cnt_ff;
            shift_up_ff <= !mprev && !mnext;
            if (mprev && mnext) begin
               seg_size_ff[sp_idx] <= prev_size + rd_size_ff + cur_size;
               seg_cnt_ff <= seg_cnt_ff - SC'(1);
            end else if (mprev) begin
               seg_size_ff[sp_idx] <= prev_size + rd_size_ff;
            end else if (mnext) begin
               seg_start_ff[si_idx] <= blk_ff;
               seg_size_ff[si_idx]  <= cur_size + rd_size_ff;
            end else begin
               seg_cnt_ff  <= seg_cnt_ff + SC'(1);
            end
         end
         if (cmd.shift_step) begin
            if (shift_up_ff) begin
               if (sh_ff <= seg_ff) begin
                  seg_start_ff[seg_ff[SW-1:0]] <= blk_ff;
                  seg_size_ff[seg_ff[SW-1:0]]  <= rd_size_ff;
               end else begin
                  seg_start_ff[sh_ff[SW-1:0]] <= seg_start_ff[sh_ff[SW-1:0] - SW'(1)];
                  seg_size_ff[sh_ff[SW-1:0]]  <= seg_size_ff[sh_ff[SW-1:0] - SW'(1)];
                  sh_ff <= sh_ff - SC'(1);
               end
            end else if (sh_ff + SC'(1) < SC'(SN) && sh_ff < seg_cnt_ff) begin
               seg_start_ff[sh_ff[SW-1:0]] <= seg_start_ff[sh_ff[SW-1:0] + SW'(1)];
               seg_size_ff[sh_ff[SW-1:0]]  <= seg_size_ff[sh_ff[SW-1:0] + SW'(1)];
               sh_ff <= sh_ff + SC'(1);
            end else begin
               sh_ff <= sh_ff + SC'(1);
            end
         end
         if (cmd.live_step && !cmd.live_clear) slot_ff <= li_idx;
         if (cmd.set_error) begin
            res_addr_ff   <= '0;
            res_status_ff <= cmd.error_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_address <= res_addr_ff;
         out_status  <= res_status_ff;
         out_used    <= used_ff;
         out_free    <= (total_ff >= used_ff) ? total_ff - used_ff : '0;
         out_total   <= total_ff;
      end
   end
endmodule

[src/ffha_control.sv]
module ffha_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic                   rsp_busy,
   input  logic                   rsp_fire,
   output logic                   idle,
   output logic                   rsp_load,
   input  ffha_pkg::ffha_sts_type sts,
   output ffha_pkg::ffha_cmd_type cmd
);
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_CHECK  = 9'b000000010,
      S_SEG    = 9'b000000100,
      S_LIVE   = 9'b000001000,
      S_LWAIT  = 9'b000010000,
      S_COMMIT = 9'b000100000,
      S_SHIFT  = 9'b001000000,
      S_RESULT = 9'b010000000,
      S_WAIT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_load = 1'b0;
      idle = 1'b0;
      case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.seg_clear = 1'b1;
            cmd.live_clear = 1'b1;
            if (!sts.op_free && sts.zero_size) begin
               cmd.set_error = 1'b1; cmd.error_code = ffha_pkg::ST_ZERO_SIZE;
               state_in = S_RESULT;
            end else if (sts.op_free && sts.null_free) begin
               cmd.set_error = 1'b1; cmd.error_code = ffha_pkg::ST_NULL_FREE;
               state_in = S_RESULT;
            end else if (sts.op_free && sts.out_range) begin
               cmd.set_error = 1'b1; cmd.error_code = ffha_pkg::ST_OUT_RANGE;
               state_in = S_RESULT;
            end else begin
               state_in = sts.op_free ? S_LIVE : S_SEG;
            end
         end
         S_SEG: begin
            if (sts.seg_done || sts.seg_hit) begin
               if (sts.op_free) begin
                  if (sts.no_merge_full) begin
                     cmd.set_error = 1'b1; cmd.error_code = ffha_pkg::ST_TABLE_FULL;
                     state_in = S_RESULT;
                  end else state_in = S_COMMIT;
               end else if (sts.seg_done) begin
                  cmd.set_error = 1'b1; cmd.error_code = ffha_pkg::ST_NO_MEMORY;
                  state_in = S_RESULT;
               end else state_in = S_LIVE;
            end else cmd.seg_step = 1'b1;
         end
         S_LIVE: begin
            cmd.live_step = 1'b1;
            state_in = S_LWAIT;
         end
         S_LWAIT: begin
            if (sts.live_hit) state_in = sts.op_free ? S_SEG : S_COMMIT;
            else if (sts.live_done) begin
               cmd.set_error = 1'b1;
               cmd.error_code = sts.op_free ? ffha_pkg::ST_UNTRACKED : ffha_pkg::ST_TABLE_FULL;
               state_in = S_RESULT;
            end else state_in = S_LIVE;
         end
         S_COMMIT: begin
            if (sts.op_free) cmd.free_commit = 1'b1;
            else cmd.alloc_commit = 1'b1;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (sts.shift_done) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_busy || rsp_fire) begin
               cmd.out_load = 1'b1;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
